// File: rtl/core/color_blob_centroid_unit_assert.svh
// Assertion macros shared by the color blob centroid RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef COLOR_BLOB_CENTROID_UNIT_ASSERT_SVH
`define COLOR_BLOB_CENTROID_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("color blob centroid assertion failed");

// Next-cycle implication, disabled during reset.
`define CBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("color blob centroid assertion failed");

`endif

// File: rtl/core/cbc_pkg.sv
// Package for the color blob centroid unit: sizes, register codes and the
// command and status types between controller and datapath. No dependencies.
package cbc_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W   = 8;
    localparam int RATIO_W = 4;
    localparam int PROD_W  = PIX_W + RATIO_W;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int FW_W    = COL_W + 1;
    localparam int CNT_W   = COL_W + ROW_W + 1;
    localparam int QUO_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int SUM_W   = CNT_W + QUO_W - 1;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int CFG_W   = FW_W;
    localparam int IDX_W   = 1;

    localparam logic [CNT_W-1:0] HIT_CAP = CNT_W'(MAX_WIDTH * MAX_HEIGHT);

    localparam logic [IDX_W-1:0] REG_BLUE_RATIO  = 1'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH = 1'd1;

    localparam logic [RATIO_W-1:0] BLUE_RATIO_RESET  = 4'd5;
    localparam logic [FW_W-1:0]    FRAME_WIDTH_RESET = 11'd320;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
    } cbc_cmd_t;

    typedef struct packed {
        logic div_zero;
    } cbc_status_t;

endpackage

// File: rtl/core/color_blob_centroid_unit.sv
// A result is valid after the divider's last step; without hits, after its first step.
// Throughput: one pixel per cycle; a frame-end pixel waits while the previous
// frame's result is being divided or has not been taken (the 10-step divider).
// Reset: asynchronous, active low; counters and sums clear, blue_ratio returns
// to 5 and frame_width to 320.
// Top level of the color blob centroid unit; depends on cbc_pkg, cbc_ctrl, cbc_datapath.

module color_blob_centroid_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cbc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [cbc_pkg::PIX_W-1:0]  red,
    input  logic [cbc_pkg::PIX_W-1:0]  green,
    input  logic [cbc_pkg::PIX_W-1:0]  blue,
    input  logic                       frame_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       found,
    output logic [cbc_pkg::COL_W-1:0]  centroid_col,
    output logic [cbc_pkg::ROW_W-1:0]  centroid_row,
    output logic [cbc_pkg::CNT_W-1:0]  hit_count
);
    import cbc_pkg::*;

    cbc_cmd_t    cmd;
    cbc_status_t status;

    cbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cbc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cmd          (cmd),
        .status       (status),
        .found        (found),
        .centroid_col (centroid_col),
        .centroid_row (centroid_row),
        .hit_count    (hit_count)
    );

endmodule

// File: rtl/core/cbc_ctrl.sv
// Controller for the color blob centroid unit: handshakes and division sequencing.
// Depends on cbc_pkg and color_blob_centroid_unit_assert.svh.
`include "color_blob_centroid_unit_assert.svh"

module cbc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                frame_end,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  cbc_pkg::cbc_status_t status,
    output cbc_pkg::cbc_cmd_t    cmd
);
    import cbc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              in_acc;

    assign in_stall   = frame_end && (state_reg != ST_IDLE);
    assign in_acc     = in_valid && !in_stall;
    assign out_valid  = (state_reg == ST_OUT);
    assign cmd.accept = in_acc;
    assign cmd.load   = in_acc && frame_end;
    assign cmd.step   = (state_reg == ST_DIV);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_DIV;
                    step_next  = STEP_W'(QUO_W - 1);
                end
            end
            ST_DIV:
            begin
                if (status.div_zero || step_reg == '0)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    `CBC_ASSERT_IMPL(a_load_only_idle, cmd.load, state_reg == ST_IDLE)
    `CBC_ASSERT_NEXT(a_div_ends, (state_reg == ST_DIV) && (step_reg == '0), state_reg == ST_OUT)
    `CBC_ASSERT_NEXT(a_out_taken, (state_reg == ST_OUT) && !out_stall, state_reg == ST_IDLE)

endmodule

// File: rtl/core/cbc_datapath.sv
// Datapath for the color blob centroid unit: configuration registers, pixel
// selection, position tracking, accumulators and a shared restoring divider.
// Depends on cbc_pkg and color_blob_centroid_unit_assert.svh.
`include "color_blob_centroid_unit_assert.svh"

module cbc_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cbc_pkg::IDX_W-1:0]  cfg_index,
    input  logic [cbc_pkg::CFG_W-1:0]  cfg_data,
    input  logic [cbc_pkg::PIX_W-1:0]  red,
    input  logic [cbc_pkg::PIX_W-1:0]  green,
    input  logic [cbc_pkg::PIX_W-1:0]  blue,
    input  cbc_pkg::cbc_cmd_t          cmd,
    output cbc_pkg::cbc_status_t       status,
    output logic                       found,
    output logic [cbc_pkg::COL_W-1:0]  centroid_col,
    output logic [cbc_pkg::ROW_W-1:0]  centroid_row,
    output logic [cbc_pkg::CNT_W-1:0]  hit_count
);
    import cbc_pkg::*;

    logic [RATIO_W-1:0] ratio_reg;
    logic [FW_W-1:0]    fw_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SUM_W-1:0]   csum_reg, rsum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]   crem_reg, rrem_reg, dvs_reg;
    logic [QUO_W-1:0]   cq_reg, rq_reg;
    logic [CNT_W-1:0]   hits_reg;

    logic [PROD_W-1:0]  prod_r, prod_g;
    logic               hit, take;
    logic [SUM_W-1:0]   csum_next, rsum_next;
    logic [CNT_W-1:0]   cnt_next;
    logic [FW_W-1:0]    eff_w, col_p1;
    logic               wrap;
    logic               c_ge, r_ge;

    assign prod_r = PROD_W'(ratio_reg) * PROD_W'(red);
    assign prod_g = PROD_W'(ratio_reg) * PROD_W'(green);
    assign hit    = (PROD_W'(blue) > prod_r) && (PROD_W'(blue) > prod_g);
    assign take   = hit && (cnt_reg < HIT_CAP);

    assign csum_next = take ? csum_reg + SUM_W'(col_reg) : csum_reg;
    assign rsum_next = take ? rsum_reg + SUM_W'(row_reg) : rsum_reg;
    assign cnt_next  = take ? cnt_reg + 1'b1 : cnt_reg;

    always_comb
    begin
        if (fw_reg == '0)
        begin
            eff_w = FW_W'(1);
        end
        else if (fw_reg > FW_W'(MAX_WIDTH))
        begin
            eff_w = FW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = fw_reg;
        end
    end

    assign col_p1 = FW_W'(col_reg) + 1'b1;
    assign wrap   = (col_p1 >= eff_w);
    assign c_ge   = (crem_reg >= dvs_reg);
    assign r_ge   = (rrem_reg >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= BLUE_RATIO_RESET;
            fw_reg    <= FRAME_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BLUE_RATIO:  ratio_reg <= cfg_data[RATIO_W-1:0];
                REG_FRAME_WIDTH: fw_reg    <= cfg_data[FW_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            csum_reg <= '0;
            rsum_reg <= '0;
            cnt_reg  <= '0;
            hits_reg <= '0;
        end
        else if (cmd.load)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            csum_reg <= '0;
            rsum_reg <= '0;
            cnt_reg  <= '0;
            hits_reg <= cnt_next;
        end
        else if (cmd.accept)
        begin
            csum_reg <= csum_next;
            rsum_reg <= rsum_next;
            cnt_reg  <= cnt_next;
            if (wrap)
            begin
                col_reg <= '0;
                if (row_reg != ROW_W'(MAX_HEIGHT - 1))
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            crem_reg <= csum_next;
            rrem_reg <= rsum_next;
            dvs_reg  <= SUM_W'(cnt_next) << (QUO_W - 1);
            cq_reg   <= '0;
            rq_reg   <= '0;
        end
        else if (cmd.step)
        begin
            if (c_ge)
            begin
                crem_reg <= crem_reg - dvs_reg;
            end
            if (r_ge)
            begin
                rrem_reg <= rrem_reg - dvs_reg;
            end
            cq_reg  <= {cq_reg[QUO_W-2:0], c_ge};
            rq_reg  <= {rq_reg[QUO_W-2:0], r_ge};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    assign status.div_zero = (hits_reg == '0);
    assign found           = (hits_reg != '0);
    assign centroid_col    = found ? cq_reg[COL_W-1:0] : '0;
    assign centroid_row    = found ? rq_reg[ROW_W-1:0] : '0;
    assign hit_count       = hits_reg;

    `CBC_ASSERT_IMPL(a_count_capped, 1'b1, cnt_reg <= HIT_CAP)
    `CBC_ASSERT_NEXT(a_divisor_shifts, cmd.step && !cmd.load, dvs_reg == ($past(dvs_reg) >> 1))

endmodule

// File: tb/testbench.sv
// Self-checking testbench for color_blob_centroid_unit: pixel words go in under random
// idling, each frame's centroid word is checked against an in-bench tracker of the frame.
// Depends on cbc_pkg and the RTL of the unit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_ITEMS   = 620;

    typedef struct packed {
        logic             found;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] count;
    } centroid_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [PIX_W-1:0]   red = '0;
    logic [PIX_W-1:0]   green = '0;
    logic [PIX_W-1:0]   blue = '0;
    logic               frame_end = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               found;
    logic [COL_W-1:0]   centroid_col;
    logic [ROW_W-1:0]   centroid_row;
    logic [CNT_W-1:0]   hit_count;

    logic [RATIO_W-1:0] ratio_cfg;
    logic [FW_W-1:0]    width_cfg;
    logic [COL_W-1:0]   col_pos;
    logic [ROW_W-1:0]   row_pos;
    logic [SUM_W-1:0]   col_acc;
    logic [SUM_W-1:0]   row_acc;
    logic [CNT_W-1:0]   hits;

    centroid_t          pending_centroids[$];
    centroid_t          oldest;
    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 no_idle = 1'b0;

    color_blob_centroid_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .centroid_col (centroid_col),
        .centroid_row (centroid_row),
        .hit_count    (hit_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 24);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_centroids.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: found=%0d col=%0d row=%0d count=%0d",
                             found, centroid_col, centroid_row, hit_count);
            end
            else
            begin
                oldest = pending_centroids.pop_front();
                if (found !== oldest.found || centroid_col !== oldest.col ||
                    centroid_row !== oldest.row || hit_count !== oldest.count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected found=%0d col=%0d row=%0d count=%0d,",
                                  " got found=%0d col=%0d row=%0d count=%0d"},
                                 oldest.found, oldest.col, oldest.row, oldest.count,
                                 found, centroid_col, centroid_row, hit_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic clear_tracker();
        col_pos = '0;
        row_pos = '0;
        col_acc = '0;
        row_acc = '0;
        hits    = '0;
    endtask

    task automatic track_pixel(input logic [PIX_W-1:0] r, g, b, input logic last);
        int        eff;
        logic      hit;
        centroid_t res;
        if (width_cfg == 0)
            eff = 1;
        else if (int'(width_cfg) > MAX_WIDTH)
            eff = MAX_WIDTH;
        else
            eff = int'(width_cfg);
        hit = (int'(b) > int'(ratio_cfg) * int'(r)) && (int'(b) > int'(ratio_cfg) * int'(g));
        if (hit && hits < HIT_CAP)
        begin
            col_acc = col_acc + col_pos;
            row_acc = row_acc + row_pos;
            hits    = hits + 1'b1;
        end
        if (last)
        begin
            res.found = (hits != 0);
            res.col   = (hits != 0) ? COL_W'(col_acc / hits) : '0;
            res.row   = (hits != 0) ? ROW_W'(row_acc / hits) : '0;
            res.count = hits;
            pending_centroids.push_back(res);
            clear_tracker();
        end
        else if (int'(col_pos) + 1 >= eff)
        begin
            col_pos = '0;
            if (int'(row_pos) + 1 < MAX_HEIGHT)
                row_pos = row_pos + 1'b1;
        end
        else
            col_pos = col_pos + 1'b1;
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        red       <= r;
        green     <= g;
        blue      <= b;
        frame_end <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_pixel(r, g, b, last);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_centroids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_BLUE_RATIO)
            ratio_cfg = val[RATIO_W-1:0];
        else if (idx == REG_FRAME_WIDTH)
            width_cfg = val[FW_W-1:0];
        @(posedge clk);
    endtask

    task automatic random_pixel(output logic [PIX_W-1:0] r, g, b);
        int pick;
        int lim;
        pick = $urandom_range(0, 3);
        r = PIX_W'($urandom);
        g = PIX_W'($urandom);
        b = PIX_W'($urandom);
        if (pick == 1)
        begin
            lim = int'(b) / (int'(ratio_cfg) + 1);
            r = PIX_W'($urandom_range(0, lim));
            g = PIX_W'($urandom_range(0, lim));
        end
        else if (pick == 2 && ratio_cfg != 0)
        begin
            lim = int'(b) / int'(ratio_cfg);
            r = PIX_W'(lim);
            g = PIX_W'($urandom_range(0, lim));
            if ($urandom_range(0, 1) == 1)
            begin
                r = g;
                g = PIX_W'(lim);
            end
        end
    endtask

    task automatic test_default_registers();
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd51, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd51, 8'd255, 1'b0);
        send_pixel(8'd50, 8'd50, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd1, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    endtask

    task automatic test_ratio_thresholds();
        settle();
        write_reg(REG_BLUE_RATIO, CFG_W'(0));
        write_reg(REG_FRAME_WIDTH, CFG_W'(2));
        send_pixel(8'd255, 8'd255, 8'd1, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd128, 8'd7, 8'd200, 1'b1);
        settle();
        write_reg(REG_BLUE_RATIO, CFG_W'(1));
        send_pixel(8'd254, 8'd254, 8'd255, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd1, 1'b1);
        settle();
        write_reg(REG_BLUE_RATIO, CFG_W'(15));
        send_pixel(8'd16, 8'd16, 8'd255, 1'b0);
        send_pixel(8'd17, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd17, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        settle();
        write_reg(REG_BLUE_RATIO, CFG_W'(5));
    endtask

    task automatic test_width_limits();
        int widths[5] = '{0, 1, 1024, 1025, 2047};
        int n;
        foreach (widths[i])
        begin
            settle();
            write_reg(REG_FRAME_WIDTH, CFG_W'(widths[i]));
            n = (widths[i] <= 1) ? 6 : 40;
            for (int k = 0; k < n; k++)
                send_pixel(8'd0, 8'd0, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'd255,
                           k == n - 1);
        end
    endtask

    task automatic test_midframe_changes();
        settle();
        write_reg(REG_BLUE_RATIO, CFG_W'(5));
        write_reg(REG_FRAME_WIDTH, CFG_W'(8));
        for (int k = 0; k < 6; k++)
            send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(3));
        for (int k = 0; k < 4; k++)
            send_pixel(8'd1, 8'd2, 8'd255, 1'b0);
        settle();
        write_reg(REG_BLUE_RATIO, CFG_W'(15));
        send_pixel(8'd16, 8'd16, 8'd255, 1'b0);
        send_pixel(8'd20, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        settle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(1024));
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    endtask

    task automatic test_random_frames();
        int               items;
        int               phase;
        int               pick;
        int               len;
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            settle();
            no_idle = (phase == 1);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_BLUE_RATIO,
                          CFG_W'(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 15)));
            pick = $urandom_range(0, 9);
            if (pick < 7)
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(1, 24)));
            else if (pick == 7)
                write_reg(REG_FRAME_WIDTH, CFG_W'(0));
            else if (pick == 8)
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(1025, 2047)));
            else
                write_reg(REG_FRAME_WIDTH, CFG_W'($urandom_range(0, 2047)));
            repeat ($urandom_range(3, 6))
            begin
                len = $urandom_range(1, 80);
                if (items + len > RANDOM_ITEMS)
                    len = (RANDOM_ITEMS > items) ? RANDOM_ITEMS - items : 1;
                for (int k = 0; k < len; k++)
                begin
                    random_pixel(r, g, b);
                    send_pixel(r, g, b, k == len - 1);
                end
                items += len;
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        ratio_cfg = BLUE_RATIO_RESET;
        width_cfg = FRAME_WIDTH_RESET;
        clear_tracker();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_ratio_thresholds();
        test_width_limits();
        test_midframe_changes();
        test_random_frames();
        settle();
        if (errors == 0 && pending_centroids.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
